/* rtl/k_bonacci_term_mod_assert.svh */
// Assertion macros used by the checker file of the k-bonacci block.
`ifndef K_BONACCI_TERM_MOD_ASSERT_SVH
`define K_BONACCI_TERM_MOD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kb_pkg.sv */
package kb_pkg;

  // Modulus of every term.
  localparam int unsigned TermMod = 1000007;

  // Field widths.
  localparam int TermW  = 20;
  localparam int OrderW = 7;
  localparam int IndexW = 32;

  // The modular adder works two bits above a term.
  localparam int SumW = TermW + 2;
  localparam logic [SumW-1:0] TermModW = SumW'(TermMod);

  typedef logic [TermW-1:0]  term_t;
  typedef logic [OrderW-1:0] order_t;
  typedef logic [IndexW-1:0] index_t;

endpackage

/* rtl/kb_ring.sv */
module kb_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  kb_pkg::term_t   wdata,
  input  logic [AW-1:0]   raddr,
  output kb_pkg::term_t   rdata
);
  import kb_pkg::*;

  term_t mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/kb_mod_unit.sv */
module kb_mod_unit (
  input  kb_pkg::term_t a,
  input  kb_pkg::term_t b,
  input  kb_pkg::term_t c,
  output kb_pkg::term_t y
);
  import kb_pkg::*;

  logic [SumW-1:0] raw;
  logic [SumW-1:0] once;

  // Computes (a + b - c) mod TermMod for operands already below the modulus.
  // Adding the modulus first keeps the value positive; it then lies below
  // three times the modulus, so two conditional subtracts finish the job.
  always_comb begin
    raw  = SumW'(a) + SumW'(b) + TermModW - SumW'(c);
    once = (raw >= TermModW) ? raw - TermModW : raw;
    y    = (once >= TermModW) ? TermW'(once - TermModW) : TermW'(once);
  end

endmodule

/* rtl/k_bonacci_term_mod.sv */
// k-bonacci term generator, modulo 1000007.
// Input channel (in_valid / in_stall) carries a query: order k and a
// one-based term_index n. A transfer takes place when in_valid is high and
// in_stall is low. Terms 1..k are 0..k-1; each later term is the sum of the
// k terms before it. Queries with k below 2, k above MAX_ORDER or n equal to
// 0 are dropped and produce nothing.
// Output channel (out_valid / out_stall) carries one term_value per query.
// When n <= k the term goes straight to hand-off; otherwise the block loads
// the window ring, then generates the n - k later terms (one per cycle
// through the shared modular adder and the ring memory's single read port),
// then hands the result off. The block takes one query at a time and holds
// in_stall high from the transfer until the result is loaded into the
// output register, so it may accept the next query while that result waits.
// A stalled result holds its value in the output register until taken.
// Reset (rst, synchronous) clears the sequencer and the output valid; the
// ring needs no clearing because each query loads it before reading it.
module k_bonacci_term_mod #(
  parameter int MAX_ORDER = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  kb_pkg::order_t order,
  input  kb_pkg::index_t term_index,
  output logic           out_valid,
  input  logic           out_stall,
  output kb_pkg::term_t  term_value
);
  import kb_pkg::*;

  localparam int PtrW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]      state;
  logic [PtrW-1:0] ptr;
  logic [PtrW-1:0] ptr_next;
  order_t          order_last;
  index_t          steps_left;
  term_t           window_sum;
  term_t           result;

  logic  accept;
  logic  query_ok;
  logic  early;
  logic  ptr_wrap;
  logic  out_free;
  logic  ring_we;
  term_t ring_wdata;
  term_t oldest;
  term_t unit_b;
  term_t unit_c;
  term_t unit_y;

  // Input handshake and query screening.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign query_ok = (order >= order_t'(2)) && (32'(order) <= 32'(MAX_ORDER)) &&
                    (term_index != '0);
  assign early    = (term_index <= IndexW'(order));

  // The ring pointer walks 0..k-1 and wraps.
  assign ptr_wrap = (32'(ptr) == 32'(order_last));
  assign ptr_next = ptr_wrap ? '0 : ptr + PtrW'(1);

  // The output register is free when empty or when its result leaves now.
  assign out_free = !out_valid || !out_stall;

  // While loading, the ring takes 0..k-1 and the sum accumulates them.
  // While stepping, the new term is the current sum; it replaces the oldest
  // term and the sum becomes sum + new - oldest.
  assign ring_we    = (state == ST_FILL) || (state == ST_STEP);
  assign ring_wdata = (state == ST_STEP) ? window_sum : TermW'(ptr);
  assign unit_b     = (state == ST_STEP) ? window_sum : TermW'(ptr);
  assign unit_c     = (state == ST_STEP) ? oldest : '0;

  kb_mod_unit u_mod (
    .a (window_sum),
    .b (unit_b),
    .c (unit_c),
    .y (unit_y)
  );

  // The read address runs one entry ahead so the oldest term is ready.
  kb_ring #(
    .DEPTH (MAX_ORDER),
    .AW    (PtrW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr),
    .wdata (ring_wdata),
    .raddr (ptr_next),
    .rdata (oldest)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ptr        <= '0;
      window_sum <= '0;
      steps_left <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && query_ok) begin
            order_last <= order - order_t'(1);
            ptr        <= '0;
            window_sum <= '0;
            if (early) begin
              result <= TermW'(term_index - index_t'(1));
              state  <= ST_DONE;
            end else begin
              steps_left <= term_index - IndexW'(order);
              state      <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          window_sum <= unit_y;
          ptr        <= ptr_next;
          if (ptr_wrap) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          window_sum <= unit_y;
          ptr        <= ptr_next;
          steps_left <= steps_left - index_t'(1);
          if (steps_left == index_t'(1)) begin
            result <= window_sum;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid  <= 1'b1;
        term_value <= result;
      end
    end
  end

endmodule

/* rtl/kb_checker.sv */
`include "k_bonacci_term_mod_assert.svh"

module kb_checker #(
  parameter int MAX_ORDER = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input kb_pkg::order_t order,
  input kb_pkg::index_t term_index,
  input logic           out_valid,
  input logic           out_stall,
  input kb_pkg::term_t  term_value
);
  import kb_pkg::*;

  // A stalled result stays offered.
  `KB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")

  // A stalled result keeps its value.
  `KB_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(term_value), "result changed")

  // Every delivered term is reduced.
  `KB_ASSERT_NOW(a_reduced, clk, rst, out_valid, term_value < TermW'(TermMod), "term not reduced")

  // A query dropped for k below 2 or n equal to 0 leaves the block free for the next transfer.
  `KB_ASSERT_NEXT(a_drop_idle, clk, rst, in_valid && !in_stall && (order < 7'd2 || term_index == 32'd0), !in_stall, "dropped query made the block busy")

  // A valid query keeps the block busy in the next cycle.
  `KB_ASSERT_NEXT(a_query_busy, clk, rst, in_valid && !in_stall && order >= 7'd2 && 32'(order) <= 32'(MAX_ORDER) && term_index != 32'd0, in_stall, "valid query not taken")

endmodule

bind k_bonacci_term_mod kb_checker #(
  .MAX_ORDER (MAX_ORDER)
) u_kb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .order      (order),
  .term_index (term_index),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .term_value (term_value)
);
